/* rtl/core/svpb_pkg.sv */
package svpb_pkg;

   // field widths
   localparam int FUNC_W   = 2;
   localparam int ID_W     = 8;
   localparam int ANGLE_W  = 10;
   localparam int PULSE_W  = 16;
   localparam int TIME_W   = 16;
   localparam int BYTE_W   = 8;

   // mapping datapath widths
   localparam int AOFF_W   = ANGLE_W + 2;          // mirrored angle minus min angle
   localparam int DPULSE_W = PULSE_W + 1;          // signed pulse span
   localparam int PROD_W   = AOFF_W + DPULSE_W;    // signed product
   localparam int MAG_W    = PROD_W - 1;           // product magnitude
   localparam int SPAN_W   = ANGLE_W;              // angle span, known non-negative

   // sync bookkeeping
   localparam int SYNC_IDX_W = 4;
   localparam logic [SYNC_IDX_W-1:0] SYNC_IDX_MAX = '1;

   localparam int DEF_TABLE_DEPTH = 8;

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SYNC = 2'd2;

   // packet bytes
   localparam logic [BYTE_W-1:0] PKT_HEADER    = 8'hFF;
   localparam logic [BYTE_W-1:0] PKT_WRITE_LEN = 8'h07;
   localparam logic [BYTE_W-1:0] INST_WRITE    = 8'h03;
   localparam logic [BYTE_W-1:0] REG_GOAL_POS  = 8'h2A;
   localparam logic [BYTE_W-1:0] ID_BROADCAST  = 8'hFE;
   localparam logic [BYTE_W-1:0] INST_SYNC     = 8'h83;
   localparam logic [BYTE_W-1:0] SYNC_DATA_LEN = 8'h04;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle_lo;
      logic signed [ANGLE_W-1:0] angle_hi;
      logic [PULSE_W-1:0]        min_pulse;
      logic [PULSE_W-1:0]        max_pulse;
      logic                      reversed;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_CHECK,
      ST_DIVGO,
      ST_DIV,
      ST_SYNC_END,
      ST_ERR,
      ST_HEAD,
      ST_BODY,
      ST_CHK
   } state_type;

   function automatic int addr_width(input int depth);
      int w;
      begin
         w = (depth > 1) ? $clog2(depth) : 1;
         return w;
      end
   endfunction

endpackage

/* rtl/core/svpb_ram.sv */
module svpb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = svpb_pkg::addr_width(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/svpb_div.sv */
module svpb_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [svpb_pkg::MAG_W-1:0]  dividend,
   input  logic [svpb_pkg::SPAN_W-1:0] divisor,
   output logic                        done,
   output logic [svpb_pkg::MAG_W-1:0]  quotient
);

   import svpb_pkg::*;

   localparam int CNT_W = $clog2(MAG_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [SPAN_W-1:0] rem_ff, rem_in;
   logic [SPAN_W-1:0] dvs_ff, dvs_in;
   logic [SPAN_W:0]   rem_sh;
   logic [SPAN_W:0]   rem_sub;
   logic              ge;

   // restoring division, one quotient bit a cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[MAG_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MAG_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[MAG_W-2:0], ge};
         rem_in = ge ? rem_sub[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/servo_angle_packet_builder.sv */
// Servo angle packet builder. A request is taken when start is high and busy is low; func 0
// loads one servo table entry, func 1 maps one angle and sends an 11-byte goal-position write
// packet, func 2 adds one element to a sync-write group and, on the element marked last, sends
// the whole sync-write packet (or one error result if any element of the group failed). Bytes
// leave one per cycle on rsp_packet_byte, each marked by rsp_strobe for exactly one cycle, and
// the receiver cannot stall them, so it must take a byte on every cycle that carries the strobe.
// A load writes one table entry and returns to idle. A move does a table read, a range check
// with the pulse-by-angle multiply, a pass through the 28-step shift-subtract divider, then
// 10 header/data bytes and the checksum. A sync element does the same read, check and divide,
// and the last one also sends 8 + 5n bytes for n servos. Failed checks skip the divider.
// The servo table and the buffered sync positions sit in two single-port-read RAMs.
module servo_angle_packet_builder #(
   parameter int TABLE_DEPTH = svpb_pkg::DEF_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [svpb_pkg::FUNC_W-1:0]         req_func,
   input  logic [svpb_pkg::ID_W-1:0]           req_servo_id,
   input  logic signed [svpb_pkg::ANGLE_W-1:0] req_angle,
   input  logic [svpb_pkg::TIME_W-1:0]         req_move_time,
   input  logic                                req_last_element,
   input  logic signed [svpb_pkg::ANGLE_W-1:0] req_angle_lo,
   input  logic signed [svpb_pkg::ANGLE_W-1:0] req_angle_hi,
   input  logic [svpb_pkg::PULSE_W-1:0]        req_min_pulse,
   input  logic [svpb_pkg::PULSE_W-1:0]        req_max_pulse,
   input  logic                                req_reversed,
   input  logic                                req_present,
   output logic                                rsp_strobe,
   output logic [svpb_pkg::BYTE_W-1:0]         rsp_packet_byte,
   output logic                                rsp_packet_end,
   output logic                                rsp_status
);

   import svpb_pkg::*;

   localparam int SYNC_CAP = TABLE_DEPTH - 1;
   localparam int TA_W     = addr_width(TABLE_DEPTH);
   localparam int SA_W     = addr_width(SYNC_CAP);
   localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int EW       = $bits(entry_type);

   // byte slots within the streamed packet
   localparam logic [3:0] HEAD_LAST_MOVE = 4'd9;
   localparam logic [3:0] HEAD_LAST_SYNC = 4'd6;
   localparam logic [3:0] SUM_FROM       = 4'd2;
   localparam logic [2:0] SUB_ID         = 3'd0;
   localparam logic [2:0] SUB_POS_HI     = 3'd1;
   localparam logic [2:0] SUB_POS_LO     = 3'd2;
   localparam logic [2:0] SUB_TIME_HI    = 3'd3;
   localparam logic [2:0] SUB_TIME_LO    = 3'd4;

   state_type state_ff, state_in;

   // captured request
   logic [FUNC_W-1:0]         func_ff;
   logic signed [ANGLE_W-1:0] angle_ff;
   logic [TIME_W-1:0]         mtime_ff;
   logic                      last_ff;
   entry_type                 ld_entry_ff;
   logic                      ld_present_ff;
   logic [ID_W-1:0]           work_id_ff, work_id_in;

   // table bookkeeping
   logic [TABLE_DEPTH-1:0]    present_ff, present_in;
   logic [CNT_W-1:0]          present_count_ff, present_count_in;

   // sync group state
   logic [SYNC_IDX_W-1:0]     sync_index_ff, sync_index_in;
   logic                      sync_error_ff, sync_error_in;
   logic [TIME_W-1:0]         sync_time_ff, sync_time_in;

   // mapping datapath
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [SPAN_W-1:0]         span_ff, span_in;
   logic                      span_zero_ff, span_zero_in;
   logic [PULSE_W-1:0]        base_ff, base_in;
   logic [PULSE_W-1:0]        pos_ff, pos_in;

   // packet streaming
   logic [3:0]                byte_cnt_ff, byte_cnt_in;
   logic [SA_W-1:0]           grp_ff, grp_in;
   logic [2:0]                sub_ff, sub_in;
   logic [BYTE_W-1:0]         sum_ff, sum_in;

   // result register
   logic                      strobe_ff, strobe_in;
   logic [BYTE_W-1:0]         byte_ff, byte_in;
   logic                      end_ff, end_in;
   logic                      status_ff, status_in;

   logic                      accept;

   // table ram
   logic                      tbl_wr_en;
   logic                      tbl_rd_en;
   logic [EW-1:0]             tbl_rd_raw;
   entry_type                 entry;

   // sync position ram
   logic                      pos_wr_en;
   logic [PULSE_W-1:0]        pos_rd_data;

   // divider
   logic                      div_start;
   logic                      div_done;
   logic [MAG_W-1:0]          div_quo;
   logic [MAG_W-1:0]          div_dividend;
   logic [PROD_W-1:0]         prod_abs;

   // check stage
   logic                      id_ok;
   logic                      entry_present;
   logic                      in_range;
   logic                      sync_ok;
   logic                      check_ok;
   logic signed [AOFF_W-1:0]  ang_x, min_x, max_x, mir_x, aoff_x;
   logic signed [DPULSE_W-1:0] dpulse;
   logic signed [ANGLE_W:0]   span_x;
   logic [PULSE_W-1:0]        q16;
   logic [ID_W-1:0]           grp_id;
   logic [BYTE_W-1:0]         sync_len;
   logic [BYTE_W-1:0]         emit_byte;
   logic                      emit;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   svpb_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (work_id_ff[TA_W-1:0]),
      .wr_data (ld_entry_ff),
      .rd_en   (tbl_rd_en),
      .rd_addr (work_id_ff[TA_W-1:0]),
      .rd_data (tbl_rd_raw)
   );

   assign entry = entry_type'(tbl_rd_raw);

   svpb_ram #(
      .WIDTH (PULSE_W),
      .DEPTH (SYNC_CAP)
   ) u_sync_pos (
      .clock   (clock),
      .wr_en   (pos_wr_en),
      .wr_addr (sync_index_ff[SA_W-1:0]),
      .wr_data (pos_in),
      .rd_en   (1'b1),
      .rd_addr (grp_ff),
      .rd_data (pos_rd_data)
   );

   // magnitude of the product, sign restored after the divide
   assign prod_abs     = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
   assign div_dividend = prod_abs[MAG_W-1:0];

   svpb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // range check and mapping operands, straight off the table read
   always_comb begin
      id_ok         = (work_id_ff < ID_W'(TABLE_DEPTH));
      entry_present = id_ok ? present_ff[work_id_ff[TA_W-1:0]] : 1'b0;
      in_range      = !(angle_ff < entry.angle_lo) && !(angle_ff > entry.angle_hi);
      sync_ok       = (func_ff != FUNC_SYNC) ||
                      ((work_id_ff <= ID_W'(present_count_ff)) &&
                       (sync_index_ff < SYNC_IDX_W'(SYNC_CAP)));
      check_ok      = entry_present && in_range && sync_ok;
      ang_x  = {{2{angle_ff[ANGLE_W-1]}}, angle_ff};
      min_x  = {{2{entry.angle_lo[ANGLE_W-1]}}, entry.angle_lo};
      max_x  = {{2{entry.angle_hi[ANGLE_W-1]}}, entry.angle_hi};
      mir_x  = entry.reversed ? (max_x - ang_x) : ang_x;
      aoff_x = mir_x - min_x;
      dpulse = $signed({1'b0, entry.max_pulse}) - $signed({1'b0, entry.min_pulse});
      span_x = {entry.angle_hi[ANGLE_W-1], entry.angle_hi} -
               {entry.angle_lo[ANGLE_W-1], entry.angle_lo};
      // truncation toward zero: divide magnitudes, then negate the low bits
      if (span_zero_ff) begin
         q16 = '0;
      end else if (prod_ff[PROD_W-1]) begin
         q16 = PULSE_W'(0) - div_quo[PULSE_W-1:0];
      end else begin
         q16 = div_quo[PULSE_W-1:0];
      end
      grp_id   = ID_W'(grp_ff) + ID_W'(1);
      sync_len = BYTE_W'((work_id_ff << 2) + work_id_ff + ID_W'(4));
   end

   // next state and outputs
   always_comb begin
      state_in         = state_ff;
      work_id_in       = work_id_ff;
      present_in       = present_ff;
      present_count_in = present_count_ff;
      sync_index_in    = sync_index_ff;
      sync_error_in    = sync_error_ff;
      sync_time_in     = sync_time_ff;
      prod_in          = prod_ff;
      span_in          = span_ff;
      span_zero_in     = span_zero_ff;
      base_in          = base_ff;
      pos_in           = q16 + base_ff;
      byte_cnt_in      = byte_cnt_ff;
      grp_in           = grp_ff;
      sub_in           = sub_ff;
      sum_in           = sum_ff;
      tbl_wr_en        = 1'b0;
      tbl_rd_en        = 1'b0;
      pos_wr_en        = 1'b0;
      div_start        = 1'b0;
      emit             = 1'b0;
      emit_byte        = '0;
      end_in           = 1'b0;
      status_in        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_SYNC) begin
                  work_id_in = ID_W'(sync_index_ff) + ID_W'(1);
                  if (sync_index_ff == '0) begin
                     sync_time_in = req_move_time;
                  end
                  state_in = ST_READ;
               end else if (req_func == FUNC_MOVE) begin
                  work_id_in = req_servo_id;
                  state_in   = ST_READ;
               end else if (req_func == FUNC_LOAD) begin
                  work_id_in = req_servo_id;
                  state_in   = ST_LOAD;
               end
            end
         end

         ST_LOAD: begin
            if (id_ok) begin
               tbl_wr_en = 1'b1;
               present_in[work_id_ff[TA_W-1:0]] = ld_present_ff;
               present_count_in = present_count_ff
                                  - CNT_W'(present_ff[work_id_ff[TA_W-1:0]])
                                  + CNT_W'(ld_present_ff);
            end
            state_in = ST_IDLE;
         end

         ST_READ: begin
            tbl_rd_en = id_ok;
            state_in  = ST_CHECK;
         end

         ST_CHECK: begin
            prod_in      = dpulse * aoff_x;
            span_in      = span_x[SPAN_W-1:0];
            span_zero_in = (entry.angle_hi == entry.angle_lo);
            base_in      = entry.min_pulse;
            if (check_ok) begin
               state_in = ST_DIVGO;
            end else if (func_ff == FUNC_SYNC) begin
               sync_error_in = 1'b1;
               state_in      = ST_SYNC_END;
            end else begin
               state_in = ST_ERR;
            end
         end

         ST_DIVGO: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end

         ST_DIV: begin
            if (div_done) begin
               if (func_ff == FUNC_SYNC) begin
                  pos_wr_en = 1'b1;
                  state_in  = ST_SYNC_END;
               end else begin
                  byte_cnt_in = '0;
                  sum_in      = '0;
                  state_in    = ST_HEAD;
               end
            end
         end

         ST_SYNC_END: begin
            if (sync_index_ff != SYNC_IDX_MAX) begin
               sync_index_in = sync_index_ff + SYNC_IDX_W'(1);
            end
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else begin
               sync_index_in = '0;
               sync_error_in = 1'b0;
               if (sync_error_ff) begin
                  state_in = ST_ERR;
               end else begin
                  byte_cnt_in = '0;
                  sum_in      = '0;
                  grp_in      = '0;
                  state_in    = ST_HEAD;
               end
            end
         end

         ST_ERR: begin
            emit      = 1'b1;
            emit_byte = '0;
            end_in    = 1'b1;
            status_in = 1'b1;
            state_in  = ST_IDLE;
         end

         ST_HEAD: begin
            emit = 1'b1;
            if (func_ff == FUNC_SYNC) begin
               case (byte_cnt_ff)
                  4'd0:    emit_byte = PKT_HEADER;
                  4'd1:    emit_byte = PKT_HEADER;
                  4'd2:    emit_byte = ID_BROADCAST;
                  4'd3:    emit_byte = sync_len;
                  4'd4:    emit_byte = INST_SYNC;
                  4'd5:    emit_byte = REG_GOAL_POS;
                  default: emit_byte = SYNC_DATA_LEN;
               endcase
            end else begin
               case (byte_cnt_ff)
                  4'd0:    emit_byte = PKT_HEADER;
                  4'd1:    emit_byte = PKT_HEADER;
                  4'd2:    emit_byte = work_id_ff;
                  4'd3:    emit_byte = PKT_WRITE_LEN;
                  4'd4:    emit_byte = INST_WRITE;
                  4'd5:    emit_byte = REG_GOAL_POS;
                  4'd6:    emit_byte = pos_ff[15:8];
                  4'd7:    emit_byte = pos_ff[7:0];
                  4'd8:    emit_byte = mtime_ff[15:8];
                  default: emit_byte = mtime_ff[7:0];
               endcase
            end
            if (byte_cnt_ff >= SUM_FROM) begin
               sum_in = sum_ff + emit_byte;
            end
            byte_cnt_in = byte_cnt_ff + 4'd1;
            if ((func_ff == FUNC_SYNC) && (byte_cnt_ff == HEAD_LAST_SYNC)) begin
               sub_in   = SUB_ID;
               state_in = ST_BODY;
            end else if ((func_ff != FUNC_SYNC) && (byte_cnt_ff == HEAD_LAST_MOVE)) begin
               state_in = ST_CHK;
            end
         end

         ST_BODY: begin
            emit = 1'b1;
            case (sub_ff)
               SUB_ID:      emit_byte = grp_id;
               SUB_POS_HI:  emit_byte = pos_rd_data[15:8];
               SUB_POS_LO:  emit_byte = pos_rd_data[7:0];
               SUB_TIME_HI: emit_byte = sync_time_ff[15:8];
               default:     emit_byte = sync_time_ff[7:0];
            endcase
            sum_in = sum_ff + emit_byte;
            if (sub_ff == SUB_TIME_LO) begin
               sub_in = SUB_ID;
               if (grp_id == work_id_ff) begin
                  state_in = ST_CHK;
               end else begin
                  grp_in = grp_ff + SA_W'(1);
               end
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end

         ST_CHK: begin
            emit      = 1'b1;
            emit_byte = ~sum_ff;
            end_in    = 1'b1;
            state_in  = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      strobe_in = emit;
      byte_in   = emit_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff       <= '0;
         present_count_ff <= '0;
         sync_index_ff    <= '0;
         sync_error_ff    <= 1'b0;
         sync_time_ff     <= '0;
         byte_cnt_ff      <= '0;
         grp_ff           <= '0;
         sub_ff           <= '0;
         strobe_ff        <= 1'b0;
      end else begin
         present_ff       <= present_in;
         present_count_ff <= present_count_in;
         sync_index_ff    <= sync_index_in;
         sync_error_ff    <= sync_error_in;
         sync_time_ff     <= sync_time_in;
         byte_cnt_ff      <= byte_cnt_in;
         grp_ff           <= grp_in;
         sub_ff           <= sub_in;
         strobe_ff        <= strobe_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff                 <= req_func;
         angle_ff                <= req_angle;
         mtime_ff                <= req_move_time;
         last_ff                 <= req_last_element;
         ld_entry_ff.angle_lo    <= req_angle_lo;
         ld_entry_ff.angle_hi    <= req_angle_hi;
         ld_entry_ff.min_pulse   <= req_min_pulse;
         ld_entry_ff.max_pulse   <= req_max_pulse;
         ld_entry_ff.reversed    <= req_reversed;
         ld_present_ff           <= req_present;
      end
      if (div_done) begin
         pos_ff <= pos_in;
      end
      work_id_ff   <= work_id_in;
      prod_ff      <= prod_in;
      span_ff      <= span_in;
      span_zero_ff <= span_zero_in;
      base_ff      <= base_in;
      sum_ff       <= sum_in;
      byte_ff      <= byte_in;
      end_ff       <= end_in;
      status_ff    <= status_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_packet_byte = byte_ff;
   assign rsp_packet_end  = end_ff;
   assign rsp_status      = status_ff;

`ifndef SYNTHESIS
   // running count of present entries tracks the flag vector
   assert property (@(posedge clock) disable iff (reset)
      present_count_ff == CNT_W'($countones(present_ff)))
      else $error("present count out of step with present flags");

   // divider only finishes while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider done outside divide wait");

   // every result comes from a cycle of work
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) != ST_IDLE))
      else $error("result strobe without preceding work");

   // a closing sync element always restarts the group
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SYNC_END) && last_ff) |=> (sync_index_ff == '0) && !sync_error_ff)
      else $error("sync group not cleared after last element");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import svpb_pkg::*;

   // table depth of the instance and the number of servos a sync group can carry
   localparam int DEPTH        = DEF_TABLE_DEPTH;
   localparam int SYNC_SLOTS   = DEPTH - 1;
   localparam int LIMIT_CYCLES = 400_000;

   // the one func code the package leaves unnamed: ignored by the block
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   // one byte leaving the block, as seen on the rsp_ ports
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              err;
   } packet_byte_type;

   localparam packet_byte_type ERROR_RESULT = '{data: 8'h00, last: 1'b1, err: STATUS_BAD};

   // one request, every field at its port width
   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [ID_W-1:0]           id;
      logic signed [ANGLE_W-1:0] angle;
      logic [TIME_W-1:0]         mtime;
      logic                      last;
      logic signed [ANGLE_W-1:0] amin;
      logic signed [ANGLE_W-1:0] amax;
      logic [PULSE_W-1:0]        pmin;
      logic [PULSE_W-1:0]        pmax;
      logic                      rev;
      logic                      pres;
   } request_type;

   // how a directed row is checked: by the predictor, against a typed-in error result, or not at all
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_ERROR
   } check_kind_type;

   typedef struct packed {
      request_type    req;
      check_kind_type chk;
   } row_type;

   // predictor's copy of one servo table entry
   typedef struct packed {
      logic signed [ANGLE_W-1:0] amin;
      logic signed [ANGLE_W-1:0] amax;
      logic [PULSE_W-1:0]        pmin;
      logic [PULSE_W-1:0]        pmax;
      logic                      rev;
      logic                      pres;
   } servo_slot_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [FUNC_W-1:0]         req_func;
   logic [ID_W-1:0]           req_servo_id;
   logic signed [ANGLE_W-1:0] req_angle;
   logic [TIME_W-1:0]         req_move_time;
   logic                      req_last_element;
   logic signed [ANGLE_W-1:0] req_angle_lo;
   logic signed [ANGLE_W-1:0] req_angle_hi;
   logic [PULSE_W-1:0]        req_min_pulse;
   logic [PULSE_W-1:0]        req_max_pulse;
   logic                      req_reversed;
   logic                      req_present;
   logic                      rsp_strobe;
   logic [BYTE_W-1:0]         rsp_packet_byte;
   logic                      rsp_packet_end;
   logic                      rsp_status;

   // predictor state: servo table, present count and the open sync group
   servo_slot_type    servo_tab [DEPTH];
   int                present_cnt;
   int                sync_idx;
   bit                sync_err;
   logic [TIME_W-1:0] sync_time;
   logic [PULSE_W-1:0] sync_pos [SYNC_SLOTS];

   // bytes worked out for the latest request, and every byte still owed by the block
   packet_byte_type predicted_bytes[$];
   packet_byte_type pending_bytes[$];

   row_type         directed_rows[$];
   packet_byte_type got;
   packet_byte_type oldest;
   int              mismatch_count;
   int              cycle_count;
   bit              steady;

   servo_angle_packet_builder #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_servo_id    (req_servo_id),
      .req_angle       (req_angle),
      .req_move_time   (req_move_time),
      .req_last_element(req_last_element),
      .req_angle_lo    (req_angle_lo),
      .req_angle_hi    (req_angle_hi),
      .req_min_pulse   (req_min_pulse),
      .req_max_pulse   (req_max_pulse),
      .req_reversed    (req_reversed),
      .req_present     (req_present),
      .rsp_strobe      (rsp_strobe),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_packet_end  (rsp_packet_end),
      .rsp_status      (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // range check and linear map of one angle; 0 means invalid argument
   function automatic bit map_angle_to_pos(input int id, input int angle,
                                           output logic [PULSE_W-1:0] pos);
      servo_slot_type e;
      longint a, span, num, q;
      pos = '0;
      if (id >= DEPTH) return 1'b0;
      e = servo_tab[id];
      if (!e.pres) return 1'b0;
      if (angle < e.amin || angle > e.amax) return 1'b0;
      // mirroring can push the offset outside the span, the position then wraps
      a = e.rev ? longint'(e.amax) - angle : longint'(angle);
      span = longint'(e.amax) - longint'(e.amin);
      num = (longint'(e.pmax) - longint'(e.pmin)) * (a - longint'(e.amin));
      // signed division truncates toward zero, a zero span maps onto min pulse
      q = (span != 0) ? num / span : 0;
      pos = PULSE_W'(q + longint'(e.pmin));
      return 1'b1;
   endfunction

   function automatic void put_byte(input logic [BYTE_W-1:0] b);
      packet_byte_type pb;
      pb = '{data: b, last: 1'b0, err: STATUS_OK};
      predicted_bytes = {predicted_bytes, pb};
   endfunction

   function automatic void add_row(input row_type w);
      directed_rows = {directed_rows, w};
   endfunction

   // advances the predictor by one request and leaves its bytes in predicted_bytes
   function automatic void predict_packet(input request_type r);
      logic [PULSE_W-1:0] pos;
      logic [BYTE_W-1:0]  sum;
      int                 n, i;
      bit                 ok;
      packet_byte_type    pb;
      predicted_bytes.delete();
      case (r.func)
         FUNC_LOAD: begin
            // ids beyond the table are dropped silently
            if (r.id < DEPTH) begin
               if (servo_tab[r.id].pres) present_cnt--;
               servo_tab[r.id] = '{r.amin, r.amax, r.pmin, r.pmax, r.rev, r.pres};
               if (r.pres) present_cnt++;
            end
            return;
         end
         FUNC_MOVE: begin
            if (!map_angle_to_pos(int'(r.id), int'(r.angle), pos)) begin
               predicted_bytes = {predicted_bytes, ERROR_RESULT};
               return;
            end
            put_byte(PKT_HEADER);
            put_byte(PKT_HEADER);
            put_byte(r.id);
            put_byte(PKT_WRITE_LEN);
            put_byte(INST_WRITE);
            put_byte(REG_GOAL_POS);
            put_byte(pos[15:8]);
            put_byte(pos[7:0]);
            put_byte(r.mtime[15:8]);
            put_byte(r.mtime[7:0]);
         end
         FUNC_SYNC: begin
            // the first element of a group sets the move time for all of it
            if (sync_idx == 0) sync_time = r.mtime;
            n = sync_idx + 1;
            ok = (n <= present_cnt) && (sync_idx < SYNC_SLOTS) &&
                 map_angle_to_pos(n, int'(r.angle), pos);
            if (!ok) sync_err = 1'b1;
            else sync_pos[sync_idx] = pos;
            // element count saturates, such long groups always fail
            if (sync_idx < 15) sync_idx++;
            if (!r.last) return;
            sync_idx = 0;
            if (sync_err || n > SYNC_SLOTS) begin
               sync_err = 1'b0;
               predicted_bytes = {predicted_bytes, ERROR_RESULT};
               return;
            end
            put_byte(PKT_HEADER);
            put_byte(PKT_HEADER);
            put_byte(ID_BROADCAST);
            put_byte(BYTE_W'(5 * n + 4));
            put_byte(INST_SYNC);
            put_byte(REG_GOAL_POS);
            put_byte(SYNC_DATA_LEN);
            for (i = 0; i < n; i++) begin
               put_byte(BYTE_W'(i + 1));
               put_byte(sync_pos[i][15:8]);
               put_byte(sync_pos[i][7:0]);
               put_byte(sync_time[15:8]);
               put_byte(sync_time[7:0]);
            end
         end
         default: return;
      endcase
      // inverted sum of everything after the two header bytes
      sum = '0;
      for (i = 2; i < predicted_bytes.size(); i++) sum += predicted_bytes[i].data;
      pb = '{data: ~sum, last: 1'b1, err: STATUS_OK};
      predicted_bytes = {predicted_bytes, pb};
   endfunction

   // every field random over its full width
   function automatic request_type random_request();
      request_type r;
      r.func  = FUNC_W'($urandom);
      r.id    = ID_W'($urandom);
      r.angle = ANGLE_W'($urandom);
      r.mtime = TIME_W'($urandom);
      r.last  = 1'($urandom);
      r.amin  = ANGLE_W'($urandom);
      r.amax  = ANGLE_W'($urandom);
      r.pmin  = PULSE_W'($urandom);
      r.pmax  = PULSE_W'($urandom);
      r.rev   = 1'($urandom);
      r.pres  = 1'($urandom);
      return r;
   endfunction

   // an angle inside the entry's range where there is one, ends now and then
   function automatic logic signed [ANGLE_W-1:0] pick_angle(input int id);
      int lo, hi, roll;
      if (id >= DEPTH) return ANGLE_W'($urandom);
      lo = servo_tab[id].amin;
      hi = servo_tab[id].amax;
      if (lo > hi) return ANGLE_W'($urandom);
      roll = $urandom_range(0, 9);
      if (roll == 0) return ANGLE_W'(lo);
      if (roll == 1) return ANGLE_W'(hi);
      return ANGLE_W'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   function automatic row_type mk_row(input logic [FUNC_W-1:0] func, input int id,
                                      input int angle, input int mtime, input bit last,
                                      input int amin, input int amax, input int pmin,
                                      input int pmax, input bit rev, input bit pres,
                                      input check_kind_type chk);
      row_type w;
      w.req = '{func, ID_W'(id), ANGLE_W'(angle), TIME_W'(mtime), last,
                ANGLE_W'(amin), ANGLE_W'(amax), PULSE_W'(pmin), PULSE_W'(pmax), rev, pres};
      w.chk = chk;
      return w;
   endfunction

   // idle gap at random, then hold the request until the block takes it
   task automatic send_request(input request_type r, input check_kind_type chk);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 30) gap = $urandom_range(1, 50);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_func         <= r.func;
      req_servo_id     <= r.id;
      req_angle        <= r.angle;
      req_move_time    <= r.mtime;
      req_last_element <= r.last;
      req_angle_lo     <= r.amin;
      req_angle_hi     <= r.amax;
      req_min_pulse    <= r.pmin;
      req_max_pulse    <= r.pmax;
      req_reversed     <= r.rev;
      req_present      <= r.pres;
      do @(posedge clock); while (!(start && !busy));
      // request taken at this edge, its bytes can only show from the next one
      predict_packet(r);
      case (chk)
         CHECK_MODEL: pending_bytes = {pending_bytes, predicted_bytes};
         CHECK_ERROR: pending_bytes = {pending_bytes, ERROR_RESULT};
         default: ;
      endcase
   endtask

   // response monitor: every strobed byte is matched against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got = '{data: rsp_packet_byte, last: rsp_packet_end, err: rsp_status};
         if (pending_bytes.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected byte %02h end %0b status %0b",
                        got.data, got.last, got.err);
            mismatch_count++;
         end else begin
            oldest = pending_bytes.pop_front();
            if (got !== oldest) begin
               if (mismatch_count < 10) begin
                  $write("byte mismatch: expected %02h end %0b status %0b, ",
                         oldest.data, oldest.last, oldest.err);
                  $display("got %02h end %0b status %0b", got.data, got.last, got.err);
               end
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      request_type r;
      int          n, k, max_ok, random_items;

      mismatch_count = 0;
      cycle_count    = 0;
      steady         = 1'b0;
      present_cnt    = 0;
      sync_idx       = 0;
      sync_err       = 1'b0;
      sync_time      = '0;
      foreach (servo_tab[i]) servo_tab[i] = '0;
      foreach (sync_pos[i]) sync_pos[i] = '0;

      reset            <= 1'b1;
      start            <= 1'b0;
      req_func         <= FUNC_LOAD;
      req_servo_id     <= '0;
      req_angle        <= '0;
      req_move_time    <= '0;
      req_last_element <= 1'b0;
      req_angle_lo     <= '0;
      req_angle_hi     <= '0;
      req_min_pulse    <= '0;
      req_max_pulse    <= '0;
      req_reversed     <= 1'b0;
      req_present      <= 1'b0;

      // directed rows: func, id, angle, time, last, min/max angle, min/max pulse,
      // reversed, present, how checked
      // empty table after reset: nothing can move or sync
      add_row(mk_row(FUNC_MOVE, 1, 0, 'h1234, 0, 0, 0, 0, 0, 0, 0, CHECK_ERROR));
      add_row(mk_row(FUNC_SYNC, 0, 0, 'h0000, 1, 0, 0, 0, 0, 0, 0, CHECK_ERROR));
      // ids beyond the table, and the unused func
      add_row(mk_row(FUNC_LOAD, 8, 0, 0, 0, -5, 5, 1, 2, 0, 1, CHECK_NONE));
      add_row(mk_row(FUNC_MOVE, 8, 0, 'h0001, 0, 0, 0, 0, 0, 0, 0, CHECK_ERROR));
      add_row(mk_row(FUNC_MOVE, 255, 0, 'h0002, 0, 0, 0, 0, 0, 0, 0, CHECK_ERROR));
      add_row(mk_row(FUNC_NONE, 3, 0, 0, 0, 0, 0, 0, 0, 0, 1, CHECK_NONE));
      // full angle and pulse range, both angle ends and both time extremes
      add_row(mk_row(FUNC_LOAD, 1, 0, 0, 0, -512, 511, 0, 65535, 0, 1, CHECK_NONE));
      add_row(mk_row(FUNC_MOVE, 1, -512, 'h0000, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL));
      add_row(mk_row(FUNC_MOVE, 1, 511, 'hFFFF, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL));
      // reversed with a falling pulse span: rounding toward zero and position wrap
      add_row(mk_row(FUNC_LOAD, 2, 0, 0, 0, -90, 90, 65535, 0, 1, 1, CHECK_NONE));
      add_row(mk_row(FUNC_MOVE, 2, 90, 'h00FF, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL));
      add_row(mk_row(FUNC_MOVE, 2, -90, 'hFF00, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL));
      add_row(mk_row(FUNC_MOVE, 2, 91, 'h0003, 0, 0, 0, 0, 0, 0, 0, CHECK_ERROR));
      add_row(mk_row(FUNC_MOVE, 2, -91, 'h0004, 0, 0, 0, 0, 0, 0, 0, CHECK_ERROR));
      // zero angle span
      add_row(mk_row(FUNC_LOAD, 3, 0, 0, 0, 45, 45, 1234, 4321, 0, 1, CHECK_NONE));
      add_row(mk_row(FUNC_MOVE, 3, 45, 'h5A5A, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL));
      // min angle above max: never in range
      add_row(mk_row(FUNC_LOAD, 4, 0, 0, 0, 100, -100, 0, 1000, 0, 1, CHECK_NONE));
      add_row(mk_row(FUNC_MOVE, 4, 0, 'h0005, 0, 0, 0, 0, 0, 0, 0, CHECK_ERROR));
      add_row(mk_row(FUNC_LOAD, 0, 0, 0, 0, -10, 10, 100, 200, 0, 1, CHECK_NONE));
      // good three-servo sync group, later elements' times ignored
      add_row(mk_row(FUNC_SYNC, 77, 10, 'hABCD, 0, 0, 0, 0, 0, 0, 0, CHECK_NONE));
      add_row(mk_row(FUNC_SYNC, 0, 0, 'h1111, 0, 0, 0, 0, 0, 0, 0, CHECK_NONE));
      add_row(mk_row(FUNC_SYNC, 0, 45, 'h0000, 1, 0, 0, 0, 0, 0, 0, CHECK_MODEL));
      // group with one angle out of range
      add_row(mk_row(FUNC_SYNC, 0, 0, 'h2222, 0, 0, 0, 0, 0, 0, 0, CHECK_NONE));
      add_row(mk_row(FUNC_SYNC, 0, 100, 'h3333, 1, 0, 0, 0, 0, 0, 0, CHECK_ERROR));
      add_row(mk_row(FUNC_MOVE, 0, -10, 'h7E81, 0, 0, 0, 0, 0, 0, 0, CHECK_MODEL));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i].req, directed_rows[i].chk);

      // random part opens with a well-formed load of every entry
      random_items = 0;
      for (k = 0; k < DEPTH; k++) begin
         r = random_request();
         r.func = FUNC_LOAD;
         r.id   = ID_W'(k);
         r.pres = 1'b1;
         if (r.amin > r.amax) {r.amin, r.amax} = {r.amax, r.amin};
         send_request(r, CHECK_MODEL);
         random_items++;
      end

      while (random_items < 75) begin
         // a stretch with no idling in the middle of the run
         steady = (random_items >= 30 && random_items < 50);
         k = $urandom_range(0, 99);
         if (k < 15) begin
            // reload an entry, mostly valid and present
            r = random_request();
            r.func = FUNC_LOAD;
            if ($urandom_range(0, 99) < 85) r.id = ID_W'($urandom_range(0, DEPTH - 1));
            if ($urandom_range(0, 99) < 75 && r.amin > r.amax)
               {r.amin, r.amax} = {r.amax, r.amin};
            if ($urandom_range(0, 99) < 5) r.amax = r.amin;
            r.pres = ($urandom_range(0, 99) < 85);
            send_request(r, CHECK_MODEL);
            if (r.id < DEPTH) random_items++;
         end else if (k < 20) begin
            // unused func, ignored by the block
            r = random_request();
            r.func = FUNC_NONE;
            send_request(r, CHECK_MODEL);
         end else if (k < 55) begin
            r = random_request();
            r.func = FUNC_MOVE;
            if ($urandom_range(0, 99) < 85) r.id = ID_W'($urandom_range(0, DEPTH - 1));
            if ($urandom_range(0, 99) < 80) r.angle = pick_angle(int'(r.id));
            send_request(r, CHECK_MODEL);
            random_items++;
         end else begin
            // sync group: longest run of usable servos from id 1 bounds a good group
            max_ok = 0;
            while (max_ok < SYNC_SLOTS && max_ok < present_cnt &&
                   servo_tab[max_ok + 1].pres &&
                   servo_tab[max_ok + 1].amin <= servo_tab[max_ok + 1].amax)
               max_ok++;
            if (max_ok > 0 && $urandom_range(0, 99) < 75) n = $urandom_range(1, max_ok);
            else if ($urandom_range(0, 99) < 80) n = $urandom_range(1, SYNC_SLOTS);
            else n = $urandom_range(SYNC_SLOTS + 1, 18);
            for (k = 1; k <= n; k++) begin
               r = random_request();
               r.func = FUNC_SYNC;
               r.last = (k == n);
               if ($urandom_range(0, 99) < 90) r.angle = pick_angle(k);
               send_request(r, CHECK_MODEL);
               random_items++;
            end
         end
      end

      start <= 1'b0;
      // drain the last packet, then give the block time to misbehave
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);

      if (mismatch_count == 0 && pending_bytes.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
